// ----- sv/cgs_pkg.sv -----
// Package for the compressor gain side chain.
// Holds widths, register index codes, the config struct, controller states and datapath ops.
// No dependencies.
`timescale 1ns / 1ps

package cgs_pkg;

	localparam int DB_W     = 16;
	localparam int COEF_W   = 16;
	localparam int IDEAL_W  = 15;
	localparam int SQ_W     = 30;
	localparam int RSQ_W    = 32;
	localparam int ACC_W    = COEF_W + RSQ_W;
	localparam int CIDX_W   = 3;
	localparam int SQRT_STEPS = RSQ_W / 2;
	localparam int SCNT_W   = $clog2(SQRT_STEPS);

	localparam logic [ACC_W-1:0]   Q16_HALF = ACC_W'(32768);
	localparam logic [IDEAL_W-1:0] DB_MAX   = {IDEAL_W{1'b1}};
	localparam logic [RSQ_W-1:0]   SQRT_TOP = RSQ_W'(1) << (RSQ_W - 2);

	localparam logic [CIDX_W-1:0] CFG_THRESHOLD = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_SLOPE     = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_RMS_EN    = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_RMS_COEF  = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_REL_COEF  = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_ATK_COEF  = 3'd5;
	localparam logic [CIDX_W-1:0] CFG_MAKEUP    = 3'd6;

	typedef struct packed {
		logic signed [DB_W-1:0] threshold_db;
		logic [COEF_W-1:0]      ratio_slope;
		logic                   rms_enable;
		logic [COEF_W-1:0]      rms_coef;
		logic [COEF_W-1:0]      release_coef;
		logic [COEF_W-1:0]      attack_coef;
		logic signed [DB_W-1:0] makeup_comp_db;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_GAIN, ST_IDEAL, ST_SQ, ST_RMS_A, ST_RMS_B, ST_RMS_W,
		ST_SQRT_INIT, ST_SQRT, ST_SQRT_DONE, ST_BYPASS,
		ST_REL_A, ST_REL_B, ST_REL_W, ST_ATK_A, ST_ATK_B, ST_ATK_W, ST_OUT
	} st_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_GAIN, OP_IDEAL, OP_SQ, OP_RMS_A, OP_RMS_B, OP_RMS_W,
		OP_SQRT_INIT, OP_SQRT_STEP, OP_SQRT_DONE, OP_BYPASS,
		OP_REL_A, OP_REL_B, OP_REL_W, OP_ATK_A, OP_ATK_B, OP_ATK_W, OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic rms_en;
		logic out_busy;
	} sts_t;

endpackage

// ----- sv/compressor_gain_sidechain.sv -----
// Compressor gain side chain: configuration registers, sequencer and datapath.
// Depends on cgs_pkg, cgs_ctrl and cgs_datapath.
// ---------------------------------------------------------------------------
// Usage:
//   s_* channel: one beat per sample, tdata = level_db (signed Q7.8).
//   m_* channel: one beat per sample, tdata = gain_reduction_db (signed Q7.8).
//   cfg_* channel: register writes (index, data), always ready; write only
//   while the block is idle. Indexes beyond the register list are ignored.
// Timing:
//   With RMS on, a sample goes from the input beat through the RMS filter and
//   16 bit-pair square root iterations to the output register; off, both are skipped.
//   All multiplies go through one shared 16x32 multiply-accumulate unit.
//   The next sample is accepted the cycle after the output step, not before.
// Stall:
//   The output register holds its beat until taken; the next sample may be
//   accepted and processed meanwhile and waits in its last step if needed.
// Reset:
//   arst_n clears the filter state (RMS square, release, attack envelopes)
//   and loads register defaults (all zero, RMS enabled).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module compressor_gain_sidechain import cgs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DB_W-1:0]   s_tdata,   // [15:0] level_db
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DB_W-1:0]   m_tdata,   // [15:0] gain_reduction_db
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [DB_W-1:0]   cfg_data
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_db   <= '0;
			cfg_q.ratio_slope    <= '0;
			cfg_q.rms_enable     <= 1'b1;
			cfg_q.rms_coef       <= '0;
			cfg_q.release_coef   <= '0;
			cfg_q.attack_coef    <= '0;
			cfg_q.makeup_comp_db <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_THRESHOLD: cfg_q.threshold_db   <= cfg_data;
				CFG_SLOPE:     cfg_q.ratio_slope    <= cfg_data;
				CFG_RMS_EN:    cfg_q.rms_enable     <= cfg_data[0];
				CFG_RMS_COEF:  cfg_q.rms_coef       <= cfg_data;
				CFG_REL_COEF:  cfg_q.release_coef   <= cfg_data;
				CFG_ATK_COEF:  cfg_q.attack_coef    <= cfg_data;
				CFG_MAKEUP:    cfg_q.makeup_comp_db <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	cgs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cgs_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.sts      (sts),
		.level_db (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- sv/cgs_ctrl.sv -----
// Sequencer for the gain side chain: walks one sample through gain, RMS and sqrt
// (when RMS is enabled), release, attack and output steps. Depends on cgs_pkg.
`timescale 1ns / 1ps

module cgs_ctrl import cgs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	st_t state_q, state_d;
	logic [SCNT_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd.op   = OP_NONE;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_GAIN;
				end
			end
			ST_GAIN: begin
				cmd.op  = OP_GAIN;
				state_d = ST_IDEAL;
			end
			ST_IDEAL: begin
				cmd.op  = OP_IDEAL;
				state_d = sts.rms_en ? ST_SQ : ST_BYPASS;
			end
			ST_SQ: begin
				cmd.op  = OP_SQ;
				state_d = ST_RMS_A;
			end
			ST_RMS_A: begin
				cmd.op  = OP_RMS_A;
				state_d = ST_RMS_B;
			end
			ST_RMS_B: begin
				cmd.op  = OP_RMS_B;
				state_d = ST_RMS_W;
			end
			ST_RMS_W: begin
				cmd.op  = OP_RMS_W;
				state_d = ST_SQRT_INIT;
			end
			ST_SQRT_INIT: begin
				cmd.op  = OP_SQRT_INIT;
				cnt_d   = '0;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.op = OP_SQRT_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == SCNT_W'(SQRT_STEPS - 1)) begin
					state_d = ST_SQRT_DONE;
				end
			end
			ST_SQRT_DONE: begin
				cmd.op  = OP_SQRT_DONE;
				state_d = ST_REL_A;
			end
			ST_BYPASS: begin
				cmd.op  = OP_BYPASS;
				state_d = ST_REL_A;
			end
			ST_REL_A: begin
				cmd.op  = OP_REL_A;
				state_d = ST_REL_B;
			end
			ST_REL_B: begin
				cmd.op  = OP_REL_B;
				state_d = ST_REL_W;
			end
			ST_REL_W: begin
				cmd.op  = OP_REL_W;
				state_d = ST_ATK_A;
			end
			ST_ATK_A: begin
				cmd.op  = OP_ATK_A;
				state_d = ST_ATK_B;
			end
			ST_ATK_B: begin
				cmd.op  = OP_ATK_B;
				state_d = ST_ATK_W;
			end
			ST_ATK_W: begin
				cmd.op  = OP_ATK_W;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!sts.out_busy) begin
					cmd.op  = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/cgs_datapath.sv -----
// Datapath of the gain side chain: shared 16x32 multiply-accumulate, bit-pair
// square root, filter state and the output register. Depends on cgs_pkg.
`timescale 1ns / 1ps

module cgs_datapath import cgs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	input  logic signed [DB_W-1:0] level_db,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [DB_W-1:0]        m_tdata
);

	logic [DB_W-1:0]    ex_q;
	logic [ACC_W-1:0]   acc_q;
	logic [IDEAL_W-1:0] ideal_q;
	logic [SQ_W-1:0]    sq_q;
	logic [RSQ_W-1:0]   x_q, res_q, bit_q;
	logic [IDEAL_W-1:0] det_q;
	logic [RSQ_W-1:0]   rms_sq_q;
	logic [DB_W-1:0]    rel_env_q, atk_env_q;
	logic               out_valid_q;
	logic [DB_W-1:0]    out_data_q;

	logic [COEF_W-1:0]      mul_a;
	logic [RSQ_W-1:0]       mul_b;
	logic [ACC_W-1:0]       prod;
	logic signed [DB_W:0]   diff;
	logic [RSQ_W-1:0]       acc_hi;
	logic [RSQ_W-1:0]       trial;
	logic [DB_W-1:0]        rel_new;
	logic signed [DB_W+1:0] res_full;
	logic [DB_W-1:0]        res_sat;

	assign sts.rms_en   = cfg.rms_enable;
	assign sts.out_busy = out_valid_q & ~m_tready;
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_data_q;

	assign diff   = {level_db[DB_W-1], level_db} - {cfg.threshold_db[DB_W-1], cfg.threshold_db};
	assign acc_hi = acc_q[ACC_W-1:COEF_W];
	assign trial  = res_q + bit_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_GAIN: begin
				mul_a = cfg.ratio_slope;
				mul_b = RSQ_W'(ex_q);
			end
			OP_SQ: begin
				mul_a = COEF_W'(ideal_q);
				mul_b = RSQ_W'(ideal_q);
			end
			OP_RMS_A: begin
				mul_a = cfg.rms_coef;
				mul_b = rms_sq_q;
			end
			OP_RMS_B: begin
				mul_a = COEF_W'(0) - cfg.rms_coef;
				mul_b = RSQ_W'(sq_q);
			end
			OP_REL_A: begin
				mul_a = cfg.release_coef;
				mul_b = RSQ_W'(rel_env_q);
			end
			OP_REL_B: begin
				mul_a = COEF_W'(0) - cfg.release_coef;
				mul_b = RSQ_W'(det_q);
			end
			OP_ATK_A: begin
				mul_a = cfg.attack_coef;
				mul_b = RSQ_W'(atk_env_q);
			end
			OP_ATK_B: begin
				mul_a = COEF_W'(0) - cfg.attack_coef;
				mul_b = RSQ_W'(rel_env_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = ACC_W'(mul_a) * ACC_W'(mul_b);

	// peak catch: filtered value never drops below the new detector value
	always_comb begin
		if (cfg.release_coef == '0) begin
			rel_new = DB_W'(det_q);
		end else if (RSQ_W'(det_q) > acc_hi) begin
			rel_new = DB_W'(det_q);
		end else begin
			rel_new = acc_hi[DB_W-1:0];
		end
	end

	always_comb begin
		res_full = {2'b00, atk_env_q} - {{2{cfg.makeup_comp_db[DB_W-1]}}, cfg.makeup_comp_db};
		if (res_full > (DB_W+2)'(32767)) begin
			res_sat = 16'h7fff;
		end else if (res_full < -(DB_W+2)'(32768)) begin
			res_sat = 16'h8000;
		end else begin
			res_sat = res_full[DB_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				ex_q <= (!diff[DB_W] && diff != '0) ? diff[DB_W-1:0] : '0;
			end
			OP_GAIN, OP_RMS_A, OP_REL_A, OP_ATK_A: begin
				acc_q <= prod + Q16_HALF;
			end
			OP_RMS_B, OP_REL_B, OP_ATK_B: begin
				acc_q <= acc_q + prod;
			end
			OP_IDEAL: begin
				ideal_q <= (acc_hi > RSQ_W'(DB_MAX)) ? DB_MAX : acc_hi[IDEAL_W-1:0];
			end
			OP_SQ: begin
				sq_q <= prod[SQ_W-1:0];
			end
			OP_SQRT_INIT: begin
				x_q   <= rms_sq_q;
				res_q <= '0;
				bit_q <= SQRT_TOP;
			end
			OP_SQRT_STEP: begin
				if (x_q >= trial) begin
					x_q   <= x_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_SQRT_DONE: begin
				det_q <= (res_q > RSQ_W'(DB_MAX)) ? DB_MAX : res_q[IDEAL_W-1:0];
			end
			OP_BYPASS: begin
				det_q <= ideal_q;
			end
			OP_OUT: begin
				out_data_q <= res_sat;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rms_sq_q    <= '0;
			rel_env_q   <= '0;
			atk_env_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_RMS_W: begin
					rms_sq_q <= (cfg.rms_coef == '0) ? RSQ_W'(sq_q) : acc_hi;
				end
				OP_REL_W: begin
					rel_env_q <= rel_new;
				end
				OP_ATK_W: begin
					atk_env_q <= (cfg.attack_coef == '0) ? rel_env_q : acc_q[2*COEF_W-1:COEF_W];
				end
				default: begin
				end
			endcase
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
